[hw/rtl/smpm_pkg.sv]
// ----------------------------------------------------------------------------
// smpm_pkg
// Shared types and codes for the subset-mask partition matcher.
// ----------------------------------------------------------------------------
package smpm_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_ZERO    = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PLACE,
        S_INSERT,
        S_RESP,
        S_QCMP,
        S_EMIT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load;        // latch input transaction
        logic    scan_start;  // arm bucket scan
        logic    scan_step;   // run one bucket scan step
        logic    place;       // find insert position
        logic    insert;      // write new entry, bump fill
        logic    clear;       // empty table
        logic    qcmp;        // compare all entries with filter
        logic    emit_match;  // send next matching id
        logic    emit_single; // send one final result
        status_t status;      // status for emit_single
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        cmd_t cmd;
        logic is_zero;
        logic is_full;
        logic scan_done;
        logic match_any;
        logic match_one;
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/smpm_ram.sv]
// ----------------------------------------------------------------------------
// smpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/smpm_ctrl.sv]
// ----------------------------------------------------------------------------
// smpm_ctrl
// Sequencer for query, add and clear transactions.
// ----------------------------------------------------------------------------
module smpm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  smpm_pkg::dp_stat_t stat,
    output smpm_pkg::dp_cmd_t  cmd
);
    import smpm_pkg::*;

    state_t  state_reg, state_next;
    status_t resp_reg, resp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_ADDED;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        resp_next  = resp_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (stat.cmd)
                    CMD_QUERY: state_next = S_QCMP;
                    CMD_ADD: begin
                        priority if (stat.is_zero) begin
                            resp_next  = ST_ZERO;
                            state_next = S_RESP;
                        end else if (stat.is_full) begin
                            resp_next  = ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_CLEAR: begin
                        resp_next  = ST_CLEARED;
                        state_next = S_RESP;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (stat.scan_done) state_next = S_PLACE;
            end
            S_PLACE: state_next = S_INSERT;
            S_INSERT: begin
                resp_next  = ST_ADDED;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            S_QCMP: state_next = S_EMIT;
            S_EMIT: begin
                if (stat.out_free && (!stat.match_any || stat.match_one)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        cmd.status = resp_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECODE: begin
                cmd.scan_start = (stat.cmd == CMD_ADD);
                cmd.clear      = (stat.cmd == CMD_CLEAR);
            end
            S_SCAN:   cmd.scan_step = 1'b1;
            S_PLACE:  cmd.place     = 1'b1;
            S_INSERT: cmd.insert    = 1'b1;
            S_RESP:   cmd.emit_single = stat.out_free;
            S_QCMP:   cmd.qcmp      = 1'b1;
            S_EMIT: begin
                if (stat.out_free) begin
                    if (stat.match_any) begin
                        cmd.emit_match = 1'b1;
                    end else begin
                        cmd.emit_single = 1'b1;
                        cmd.status      = ST_NOMATCH;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

[hw/rtl/smpm_dpath.sv]
// ----------------------------------------------------------------------------
// smpm_dpath
// Entry lanes kept sorted by bucket, parallel subset compare, bucket fill
// memory with scan unit, and the result register.
// ----------------------------------------------------------------------------
module smpm_dpath #(
    parameter int FILTER_BITS = 192,
    parameter int TABLE_DEPTH = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [1:0]              in_cmd,
    input  logic [15:0]             in_id,
    input  logic [FILTER_BITS-1:0]  in_vec,
    input  smpm_pkg::dp_cmd_t       cmd,
    output smpm_pkg::dp_stat_t      stat,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [2:0]              m_status,
    output logic [15:0]             m_match_id,
    output logic                    m_last
);
    import smpm_pkg::*;

    localparam int BW = $clog2(FILTER_BITS);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Latched transaction
    cmd_t                   cmd_reg;
    logic [15:0]            id_reg;
    logic [FILTER_BITS-1:0] vec_reg;

    // Entry lanes
    logic [FILTER_BITS-1:0] lane_mask_reg [TABLE_DEPTH];
    logic [15:0]            lane_id_reg   [TABLE_DEPTH];
    logic [BW-1:0]          lane_bkt_reg  [TABLE_DEPTH];
    logic [CW-1:0]          total_reg;

    // Bucket scan
    logic [FILTER_BITS-1:0] fvalid_reg;
    logic [FILTER_BITS-1:0] rem_reg;
    logic                   pipe_v_reg;
    logic [BW-1:0]          pipe_b_reg;
    logic                   best_v_reg;
    logic [BW-1:0]          best_reg;
    logic [CW-1:0]          best_fill_reg;
    logic [CW-1:0]          pos_reg;
    logic [TABLE_DEPTH-1:0] match_reg;

    // Result register
    logic                   out_v_reg;
    logic [2:0]             out_st_reg;
    logic [15:0]            out_id_reg;
    logic                   out_last_reg;

    logic [BW-1:0]          ffs_b;
    logic [CW-1:0]          ram_q;
    logic [CW-1:0]          fill_eff;
    logic [CW-1:0]          pos_c;
    logic [TABLE_DEPTH-1:0] match_c;
    logic [IW-1:0]          midx;
    logic [TABLE_DEPTH-1:0] mbit;
    logic                   out_free;

    // Lowest pending bucket bit
    always_comb begin
        ffs_b = '0;
        for (int i = FILTER_BITS - 1; i >= 0; i--) begin
            if (rem_reg[i]) ffs_b = BW'(i);
        end
    end

    smpm_ram #(.WIDTH(CW), .DEPTH(FILTER_BITS)) u_fill (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (best_reg),
        .wdata (best_fill_reg + CW'(1)),
        .raddr (ffs_b),
        .rdata (ram_q)
    );

    assign fill_eff = fvalid_reg[pipe_b_reg] ? ram_q : '0;

    // Insert position: first stored entry with a later bucket
    always_comb begin
        pos_c = total_reg;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if ((CW'(i) < total_reg) && (lane_bkt_reg[i] > best_reg)) pos_c = CW'(i);
        end
    end

    // Subset test on every lane
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_c[i] = (CW'(i) < total_reg) && ((lane_mask_reg[i] & ~vec_reg) == '0);
        end
    end

    // Next match to send
    always_comb begin
        midx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (match_reg[i]) midx = IW'(i);
        end
        mbit = '0;
        mbit[midx] = 1'b1;
    end

    assign out_free = !out_v_reg || m_tready;

    // Transaction, scan and match registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= cmd_t'(in_cmd);
            id_reg  <= in_id;
            vec_reg <= in_vec;
        end
        if (cmd.scan_start) begin
            rem_reg    <= vec_reg;
            best_v_reg <= 1'b0;
        end
        if (cmd.scan_step) begin
            rem_reg[ffs_b] <= 1'b0;
            pipe_b_reg     <= ffs_b;
            if (pipe_v_reg && (!best_v_reg || fill_eff < best_fill_reg)) begin
                best_v_reg    <= 1'b1;
                best_reg      <= pipe_b_reg;
                best_fill_reg <= fill_eff;
            end
        end
        if (cmd.place) pos_reg <= pos_c;
        if (cmd.qcmp) match_reg <= match_c;
        else if (cmd.emit_match) match_reg <= match_reg & ~mbit;
        if (!aresetn) begin
            pipe_v_reg <= 1'b0;
        end else begin
            pipe_v_reg <= cmd.scan_step && (rem_reg != '0);
        end
    end

    // Entry lanes: shift up above the insert position
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (CW'(i) == pos_reg) begin
                    lane_mask_reg[i] <= vec_reg;
                    lane_id_reg[i]   <= id_reg;
                    lane_bkt_reg[i]  <= best_reg;
                end else if (i > 0 && CW'(i) > pos_reg) begin
                    lane_mask_reg[i] <= lane_mask_reg[(i > 0) ? i - 1 : 0];
                    lane_id_reg[i]   <= lane_id_reg[(i > 0) ? i - 1 : 0];
                    lane_bkt_reg[i]  <= lane_bkt_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // Table occupancy and bucket valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            fvalid_reg <= '0;
        end else if (cmd.clear) begin
            total_reg  <= '0;
            fvalid_reg <= '0;
        end else if (cmd.insert) begin
            total_reg            <= total_reg + CW'(1);
            fvalid_reg[best_reg] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (cmd.emit_match || cmd.emit_single) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
        if (cmd.emit_match) begin
            out_st_reg   <= ST_MATCH;
            out_id_reg   <= lane_id_reg[midx];
            out_last_reg <= (match_reg & ~mbit) == '0;
        end else if (cmd.emit_single) begin
            out_st_reg   <= cmd.status;
            out_id_reg   <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.is_zero   = (vec_reg == '0);
    assign stat.is_full   = (total_reg >= CW'(TABLE_DEPTH));
    assign stat.scan_done = (rem_reg == '0) && !pipe_v_reg;
    assign stat.match_any = (match_reg != '0);
    assign stat.match_one = (match_reg & ~mbit) == '0;
    assign stat.out_free  = out_free;

    assign m_tvalid   = out_v_reg;
    assign m_status   = out_st_reg;
    assign m_match_id = out_id_reg;
    assign m_last     = out_last_reg;
endmodule

[hw/rtl/subset_mask_partition_matcher.sv]
// ----------------------------------------------------------------------------
// subset_mask_partition_matcher
// Partition table with subset matching of query filters.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A query compares all stored masks at
// once, then matches leave the result register one a cycle while the
// receiver is ready. An add reads the bucket fill memory once for each
// set bit of the mask to find the least filled bucket, then inserts the entry.
// Clear and rejected adds skip the scan and go straight to the response.
// Entries are kept sorted by bucket, so query results come out in bucket
// order and then insertion order; the final result carries tlast.
module subset_mask_partition_matcher #(
    parameter int FILTER_BITS = 192,
    parameter int TABLE_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], part_id[17:2], word_low[81:18], word_mid[145:82],
    // word_high[209:146], zero pad
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], match_id[18:3], zero pad
    output logic [23:0]  m_tdata,
    output logic         m_tlast
);
    import smpm_pkg::*;

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic [191:0]           words;
    logic [2:0]             status;
    logic [15:0]            match_id;

    assign words = s_tdata[209:18];

    smpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smpm_dpath #(
        .FILTER_BITS (FILTER_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tdata[1:0]),
        .in_id      (s_tdata[17:2]),
        .in_vec     (words[FILTER_BITS-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_status   (status),
        .m_match_id (match_id),
        .m_last     (m_tlast)
    );

    assign m_tdata = {5'd0, match_id, status};
endmodule

[verif/tb_subset_mask_partition_matcher.sv]
// ----------------------------------------------------------------------------
// tb_subset_mask_partition_matcher
// Self-checking bench: drives queries, adds and clears through the input
// stream, predicts the result stream and compares every field.
// ----------------------------------------------------------------------------
module tb_subset_mask_partition_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import smpm_pkg::*;

    localparam int NBITS = 192;
    localparam int DEPTH = 64;
    localparam int LIMIT = 2_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One predicted result transaction
    typedef struct packed {
        status_t     status;
        logic [15:0] match_id;
        logic        last;
    } result_t;

    // Partition table model and queue of predicted results
    class partition_scoreboard;
        logic [NBITS-1:0] masks [DEPTH];
        logic [15:0]      ids [DEPTH];
        int               bucket [DEPTH];
        int               total;
        int               fill [NBITS];
        result_t          pending [$];
        int               errors;

        function void wipe();
            total = 0;
            foreach (fill[b]) fill[b] = 0;
        endfunction

        function void push(status_t st, logic [15:0] id);
            result_t r;
            r.status = st;
            r.match_id = id;
            r.last = 1'b0;
            pending = {pending, r};
        endfunction

        // Note one accepted input transaction
        function void note_input(logic [1:0] cmd, logic [15:0] id, logic [NBITS-1:0] v);
            int n0;
            int best;
            n0 = pending.size();
            best = -1;
            if (cmd == CMD_QUERY) begin
                for (int b = 0; b < NBITS; b++) begin
                    if (fill[b] == 0) continue;
                    for (int e = 0; e < total; e++)
                        if (bucket[e] == b && (masks[e] & ~v) == '0)
                            push(ST_MATCH, ids[e]);
                end
                if (pending.size() == n0) push(ST_NOMATCH, 16'd0);
            end else if (cmd == CMD_ADD) begin
                if (v == '0) push(ST_ZERO, 16'd0);
                else if (total >= DEPTH) push(ST_FULL, 16'd0);
                else begin
                    for (int b = 0; b < NBITS; b++)
                        if (v[b] && (best < 0 || fill[b] < fill[best])) best = b;
                    masks[total] = v;
                    ids[total] = id;
                    bucket[total] = best;
                    fill[best]++;
                    total++;
                    push(ST_ADDED, 16'd0);
                end
            end else if (cmd == CMD_CLEAR) begin
                wipe();
                push(ST_CLEARED, 16'd0);
            end else begin
                return; // unused code: no result
            end
            pending[pending.size()-1].last = 1'b1;
        endfunction

        // Check one accepted result transaction
        function void check_result(logic [23:0] data, logic lst);
            result_t x;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d id=%0d", data[2:0], data[18:3]);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (data[2:0] !== x.status) begin
                $error("status exp=%0d act=%0d", x.status, data[2:0]);
                errors++;
            end
            if (data[18:3] !== x.match_id) begin
                $error("match_id exp=%0d act=%0d", x.match_id, data[18:3]);
                errors++;
            end
            if (lst !== x.last) begin
                $error("last exp=%0d act=%0d", x.last, lst);
                errors++;
            end
            if (data[23:19] !== 5'd0) begin
                $error("pad exp=0 act=%0d", data[23:19]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tlast;

    partition_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    longint cycles = 0;

    subset_mask_partition_matcher dut (.*);

    always #10 aclk = ~aclk;

    // Receiver: random stalls, optional long hold-off
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Timeout
    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one transaction, with random gaps before it; tvalid stays high
    // after acceptance until the next idle cycle or transaction
    task automatic send(logic [1:0] cmd, logic [15:0] id, logic [NBITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {6'd0, v, id, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, id, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [NBITS-1:0] sparse_mask();
        logic [NBITS-1:0] m;
        int n;
        m = '0;
        n = $urandom_range(4, 1);
        repeat (n) m[$urandom_range(NBITS-1)] = 1'b1;
        return m;
    endfunction

    function automatic logic [NBITS-1:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Random mix: mostly adds and queries that hit stored masks
    task automatic random_phase(int count);
        logic [NBITS-1:0] m;
        logic [NBITS-1:0] kept [$];
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                m = sparse_mask();
                kept = {kept, m};
                send(CMD_ADD, 16'($urandom), m);
            end else if (r < 80 && kept.size() > 0) begin
                m = kept[$urandom_range(kept.size()-1)];
                repeat ($urandom_range(3)) m |= kept[$urandom_range(kept.size()-1)];
                m |= rand_wide() & rand_wide() & rand_wide();
                send(CMD_QUERY, 16'($urandom), m);
            end else if (r < 88) begin
                send(CMD_QUERY, 16'($urandom), rand_wide());
            end else if (r < 92) begin
                send(CMD_ADD, 16'($urandom), '0);
            end else if (r < 95) begin
                send(CMD_UNUSED, 16'($urandom), rand_wide());
            end else begin
                kept.delete();
                send(CMD_CLEAR, 16'($urandom), rand_wide());
            end
        end
    endtask

    initial begin
        sb = new();
        sb.wipe();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty query, zero mask, extremes, ties, unused code
        send(CMD_QUERY, 16'hFFFF, '0);
        send(CMD_ADD, 16'h0000, '0);
        send(CMD_ADD, 16'hFFFF, '1);
        send(CMD_ADD, 16'h1234, {NBITS{1'b1}});
        send(CMD_ADD, 16'h0001, 192'h1);
        send(CMD_ADD, 16'h8000, {1'b1, 191'd0});
        send(CMD_ADD, 16'h5555, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h3});
        send(CMD_QUERY, 16'h0, '1);
        send(CMD_QUERY, 16'h0, 192'h1);
        send(CMD_UNUSED, 16'hFFFF, '1);
        send(CMD_QUERY, 16'h0, {64'hFFFF_FFFF_FFFF_FFFF, 128'd0});
        send(CMD_CLEAR, 16'hFFFF, '1);
        send(CMD_QUERY, 16'h0, '1);
        drain();

        // Fill the table: 64 single-bit adds plus overflow, then a full query
        for (int i = 0; i < DEPTH + 2; i++) send(CMD_ADD, 16'(i), 192'(1) << (i % 3));
        send(CMD_QUERY, 16'h0, '1);
        // Long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send(CMD_QUERY, 16'h0, 192'h3);
                send(CMD_ADD, 16'h0, 192'h4);
                send(CMD_CLEAR, 16'h0, '0);
                s_tvalid <= 1'b0;
            end
        join
        drain();

        send_idle_pct = 25; recv_idle_pct = 46;
        random_phase(13);
        drain();
        send_idle_pct = 46; recv_idle_pct = 25;
        random_phase(13);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(12);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
